FILE: hw/rtl/sgemm_pkg.sv
// Shared types and constants of the single-precision GEMM engine.
`default_nettype none
package sgemm_pkg;

    typedef logic t_fop;
    localparam t_fop FOP_MUL = 1'b0;
    localparam t_fop FOP_ADD = 1'b1;

    typedef struct packed {
        logic start;
        t_fop op;
    } t_fpu_req;

    localparam logic [31:0] QNAN = 32'hFFC0_0000;
    localparam logic [31:0] QBIT = 32'h0040_0000;

    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_LOAD_C  = 2'd2;
    localparam logic [1:0] KIND_COMPUTE = 2'd3;

    localparam logic [2:0] REG_M     = 3'd0;
    localparam logic [2:0] REG_N     = 3'd1;
    localparam logic [2:0] REG_K     = 3'd2;
    localparam logic [2:0] REG_ALPHA = 3'd3;
    localparam logic [2:0] REG_BETA  = 3'd4;

endpackage
`default_nettype wire

FILE: hw/rtl/sgemm_fpu.sv
// Shared binary32 multiply / add unit, round to nearest even.
`default_nettype none
module sgemm_fpu
    import sgemm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_fpu_req    i_req,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [31:0]      o_res
);

    // stage 0: unpack, multiply or align/add
    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [9:0]  eae, ebe;
    logic        a_big;
    logic [9:0]  e_big, e_sml, d;
    logic [23:0] m_big, m_sml;
    logic [47:0] bm, smf, shf;
    logic        stk;
    logic [47:0] sum;
    logic        n_spec, n_sign;
    logic [31:0] n_spec_val;
    logic signed [10:0] n_e;
    logic [47:0] n_m;

    always_comb begin
        sa = i_a[31]; sb = i_b[31];
        ea = i_a[30:23]; eb = i_b[30:23];
        fa = i_a[22:0]; fb = i_b[22:0];
        a_nan  = (ea == 8'hFF) && (fa != 23'd0);
        b_nan  = (eb == 8'hFF) && (fb != 23'd0);
        a_inf  = (ea == 8'hFF) && (fa == 23'd0);
        b_inf  = (eb == 8'hFF) && (fb == 23'd0);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        ma  = {ea != 8'd0, fa};
        mb  = {eb != 8'd0, fb};
        eae = (ea == 8'd0) ? 10'd1 : {2'b0, ea};
        ebe = (eb == 8'd0) ? 10'd1 : {2'b0, eb};

        a_big = (i_a[30:0] >= i_b[30:0]);
        e_big = a_big ? eae : ebe;
        e_sml = a_big ? ebe : eae;
        m_big = a_big ? ma : mb;
        m_sml = a_big ? mb : ma;
        d     = e_big - e_sml;
        bm    = {1'b0, m_big, 23'd0};
        smf   = {1'b0, m_sml, 23'd0};
        shf   = smf >> d;
        stk   = ((shf << d) != smf) || ((d >= 10'd48) && (m_sml != 24'd0));
        if (d >= 10'd48) shf = 48'd0;
        shf[0] = shf[0] | stk;
        sum   = (sa == sb) ? (bm + shf) : (bm - shf);

        n_spec     = 1'b0;
        n_spec_val = QNAN;
        if (i_req.op == FOP_MUL) begin
            n_sign = sa ^ sb;
            n_m    = ma * mb;
            n_e    = 11'(signed'({1'b0, eae}) + signed'({1'b0, ebe}) - 11'sd127);
            if (a_nan) begin
                n_spec = 1'b1; n_spec_val = i_a | QBIT;
            end else if (b_nan) begin
                n_spec = 1'b1; n_spec_val = i_b | QBIT;
            end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                n_spec = 1'b1; n_spec_val = QNAN;
            end else if (a_inf || b_inf) begin
                n_spec = 1'b1; n_spec_val = {n_sign, 8'hFF, 23'd0};
            end
        end else begin
            n_m    = sum;
            n_e    = signed'({1'b0, e_big});
            n_sign = (sum == 48'd0) ? (sa & sb) : (a_big ? sa : sb);
            if (a_nan) begin
                n_spec = 1'b1; n_spec_val = i_a | QBIT;
            end else if (b_nan) begin
                n_spec = 1'b1; n_spec_val = i_b | QBIT;
            end else if (a_inf && b_inf && (sa != sb)) begin
                n_spec = 1'b1; n_spec_val = QNAN;
            end else if (a_inf) begin
                n_spec = 1'b1; n_spec_val = i_a;
            end else if (b_inf) begin
                n_spec = 1'b1; n_spec_val = i_b;
            end
        end
    end

    logic               r_v1, r_spec, r_sign;
    logic [31:0]        r_spec_val;
    logic signed [10:0] r_e;
    logic [47:0]        r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
        end
        r_spec     <= n_spec;
        r_spec_val <= n_spec_val;
        r_sign     <= n_sign;
        r_e        <= n_e;
        r_m        <= n_m;
    end

    // stage 1: normalize, denormalize, round
    logic [5:0]         lz;
    logic signed [10:0] e_n;
    logic [47:0]        norm;
    logic               xstk, rnd;
    logic [10:0]        esel;
    logic [6:0]         rs;
    logic [33:0]        tot;
    logic [31:0]        n_res;

    always_comb begin
        lz = 6'd47;
        for (int k = 0; k < 48; k++) begin
            if (r_m[k]) lz = 6'(47 - k);
        end
        e_n  = r_e + 11'sd1 - signed'({5'b0, lz});
        xstk = 1'b0;
        rs   = 7'd0;
        if (e_n >= 11'sd1) begin
            norm = r_m << lz;
            esel = 11'(e_n - 11'sd1);
        end else if (r_e >= 11'sd0) begin
            norm = r_m << r_e[5:0];
            esel = 11'd0;
        end else begin
            rs   = (r_e < -11'sd100) ? 7'd100 : 7'(-r_e);
            norm = r_m >> rs;
            xstk = ((norm << rs) != r_m);
            esel = 11'd0;
        end
        rnd = norm[23] & ((|norm[22:0]) | xstk | norm[24]);
        tot = {esel, 23'd0} + {10'd0, norm[47:24]} + {33'd0, rnd};
        if (r_spec) begin
            n_res = r_spec_val;
        end else if (r_m == 48'd0) begin
            n_res = {r_sign, 31'd0};
        end else if (tot >= {11'd255, 23'd0}) begin
            n_res = {r_sign, 8'hFF, 23'd0};
        end else begin
            n_res = {r_sign, tot[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_v1;
        end
        o_res <= n_res;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sgemm_alpha_beta_engine_core.sv
// Top level of the single-precision GEMM engine: stores, sequencer, config.
//
// Input channel (i_valid / o_ready) carries one word per item: i_kind selects
// load A, load B, load C or compute. Loads write one store entry and finish in
// the accept cycle. A compute word names result (i_row, i_col); the dot product
// over k_size terms is walked through one shared multiply/add unit.
// Each term reads the stores, then issues a multiply and an add, each issue
// followed by a wait; then come alpha*sum and, with beta nonzero, beta*C and
// a final add, before the result is handed off. One compute is in flight at
// a time and o_ready is low meanwhile.
// The result leaves on o_valid / i_ready through an output register, and the
// new value is written back to C. A stalled receiver holds the result; the
// next compute may run and waits only at hand-off.
// Out-of-range computes give no word; loads give none.
// Config registers via APB: m, n, k at 0x0, 0x4, 0x8, alpha 0xC, beta 0x10.
// Synchronous active-low reset returns sizes 16, alpha 1.0, beta 0.0. Store
// contents are undefined until written; no clearing pass.
`default_nettype none
module sgemm_alpha_beta_engine_core
    import sgemm_pkg::*;
#(
    parameter int MAX_M = 16,
    parameter int MAX_N = 16,
    parameter int MAX_K = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [3:0]  i_row,
    input  wire logic [3:0]  i_col,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result_bits,
    output logic [3:0]       o_result_row,
    output logic [3:0]       o_result_col
);

    localparam int DA = MAX_K * MAX_M;
    localparam int DB = MAX_K * MAX_N;
    localparam int DC = MAX_M * MAX_N;
    localparam int AWA = (DA > 1) ? $clog2(DA) : 1;
    localparam int AWB = (DB > 1) ? $clog2(DB) : 1;
    localparam int AWC = (DC > 1) ? $clog2(DC) : 1;
    localparam int LW  = $clog2(MAX_K + 1);
    localparam logic [8:0] MM9 = 9'(MAX_M);
    localparam logic [8:0] MN9 = 9'(MAX_N);
    localparam logic [8:0] MK9 = 9'(MAX_K);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_OP   = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [2:0] ST_DMUL = 3'd0;
    localparam logic [2:0] ST_DADD = 3'd1;
    localparam logic [2:0] ST_AS   = 3'd2;
    localparam logic [2:0] ST_BC   = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    // config registers
    logic [4:0]  r_m_size, r_n_size, r_k_size;
    logic [31:0] r_alpha, r_beta;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_size <= 5'd16;
            r_n_size <= 5'd16;
            r_k_size <= 5'd16;
            r_alpha  <= 32'h3F80_0000;
            r_beta   <= 32'd0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_M:     r_m_size <= pwdata[4:0];
                REG_N:     r_n_size <= pwdata[4:0];
                REG_K:     r_k_size <= pwdata[4:0];
                REG_ALPHA: r_alpha  <= pwdata;
                REG_BETA:  r_beta   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_M:     prdata = {27'd0, r_m_size};
            REG_N:     prdata = {27'd0, r_n_size};
            REG_K:     prdata = {27'd0, r_k_size};
            REG_ALPHA: prdata = r_alpha;
            REG_BETA:  prdata = r_beta;
            default:   prdata = 32'd0;
        endcase
    end

    // effective sizes, saturated to the store bounds
    logic [8:0] em, en, ek;
    assign em = ({4'd0, r_m_size} > MM9) ? MM9 : {4'd0, r_m_size};
    assign en = ({4'd0, r_n_size} > MN9) ? MN9 : {4'd0, r_n_size};
    assign ek = ({4'd0, r_k_size} > MK9) ? MK9 : {4'd0, r_k_size};

    logic beta_zero;
    assign beta_zero = (r_beta[30:0] == 31'd0);

    // sequencer registers
    logic [2:0]    r_state, r_step;
    logic [3:0]    r_i, r_j;
    logic [LW-1:0] r_l;
    logic [31:0]   r_sum, r_tmp;
    logic          r_ovalid;
    logic [31:0]   r_obits;
    logic [3:0]    r_orow, r_ocol;

    logic accept;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // stores, one write and one registered read each
    logic [31:0] mem_a [DA];
    logic [31:0] mem_b [DB];
    logic [31:0] mem_c [DC];
    logic [31:0] rd_a, rd_b, rd_c;
    logic [AWA-1:0] wa_a, ra_a;
    logic [AWB-1:0] wa_b, ra_b;
    logic [AWC-1:0] wa_c, ra_c;
    logic we_a, we_b, we_c;
    logic [31:0] wd_c;

    assign wa_a = AWA'(int'(i_row) * MAX_M + int'(i_col));
    assign wa_b = AWB'(int'(i_row) * MAX_N + int'(i_col));
    assign ra_a = AWA'(int'(r_l) * MAX_M + int'(r_i));
    assign ra_b = AWB'(int'(r_l) * MAX_N + int'(r_j));
    assign ra_c = AWC'(int'(r_j) * MAX_M + int'(r_i));

    assign we_a = accept && (i_kind == KIND_LOAD_A)
                  && ({5'd0, i_row} < MK9) && ({5'd0, i_col} < MM9);
    assign we_b = accept && (i_kind == KIND_LOAD_B)
                  && ({5'd0, i_row} < MK9) && ({5'd0, i_col} < MN9);

    logic out_go;
    assign out_go = (r_state == S_OUT) && (!r_ovalid || i_ready);

    always_comb begin
        if (out_go) begin
            we_c = 1'b1;
            wa_c = ra_c;
            wd_c = r_sum;
        end else begin
            we_c = accept && (i_kind == KIND_LOAD_C)
                   && ({5'd0, i_row} < MM9) && ({5'd0, i_col} < MN9);
            wa_c = AWC'(int'(i_col) * MAX_M + int'(i_row));
            wd_c = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[wa_a] <= i_value;
        if (we_b) mem_b[wa_b] <= i_value;
        if (we_c) mem_c[wa_c] <= wd_c;
        rd_a <= mem_a[ra_a];
        rd_b <= mem_b[ra_b];
        rd_c <= mem_c[ra_c];
    end

    // shared arithmetic unit
    t_fpu_req    fq;
    logic [31:0] fa, fb, fres;
    logic        fdone;

    always_comb begin
        fq.start = (r_state == S_OP);
        fq.op    = FOP_MUL;
        fa       = r_alpha;
        fb       = r_sum;
        case (r_step)
            ST_DMUL: begin fa = rd_a;  fb = rd_b; end
            ST_DADD: begin fq.op = FOP_ADD; fa = r_sum; fb = r_tmp; end
            ST_AS:   begin fa = r_alpha; fb = r_sum; end
            ST_BC:   begin fa = r_beta;  fb = rd_c; end
            ST_FIN:  begin fq.op = FOP_ADD; fa = r_tmp; fb = r_sum; end
            default: ;
        endcase
    end

    sgemm_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fq),
        .i_a     (fa),
        .i_b     (fb),
        .o_done  (fdone),
        .o_res   (fres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_DMUL;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_kind == KIND_COMPUTE)
                        && ({5'd0, i_row} < em) && ({5'd0, i_col} < en)) begin
                        r_i    <= i_row;
                        r_j    <= i_col;
                        r_l    <= '0;
                        r_sum  <= 32'd0;
                        r_step <= ST_DMUL;
                        r_state <= (ek == 9'd0) ? S_TAIL : S_RD;
                    end
                end
                S_RD: r_state <= S_OP;
                S_OP: r_state <= S_WAIT;
                S_WAIT: begin
                    if (fdone) begin
                        case (r_step)
                            ST_DMUL: begin
                                r_tmp   <= fres;
                                r_step  <= ST_DADD;
                                r_state <= S_OP;
                            end
                            ST_DADD: begin
                                r_sum  <= fres;
                                r_l    <= r_l + LW'(1);
                                r_step <= ST_DMUL;
                                r_state <= (9'(r_l) + 9'd1 == ek) ? S_TAIL : S_RD;
                            end
                            ST_AS: begin
                                r_sum <= fres;
                                if (beta_zero) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_step  <= ST_BC;
                                    r_state <= S_OP;
                                end
                            end
                            ST_BC: begin
                                r_tmp   <= fres;
                                r_step  <= ST_FIN;
                                r_state <= S_OP;
                            end
                            ST_FIN: begin
                                r_sum   <= fres;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_TAIL: begin
                    r_step  <= ST_AS;
                    r_state <= S_OP;
                end
                S_OUT: begin
                    if (out_go) begin
                        r_ovalid <= 1'b1;
                        r_obits  <= r_sum;
                        r_orow   <= r_i;
                        r_ocol   <= r_j;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_result_bits = r_obits;
    assign o_result_row  = r_orow;
    assign o_result_col  = r_ocol;

    // unit results only come back while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fdone |-> (r_state == S_WAIT))
        else $error("arithmetic result outside wait state");

    // an issue is always followed by the wait state
    a_op_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OP) |=> (r_state == S_WAIT))
        else $error("issue not followed by wait");

    // dot-product index stays inside k while reading
    a_l_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (9'(r_l) < ek))
        else $error("dot index beyond k");

    // a result is handed off only into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && !i_ready) |=> (r_state == S_OUT))
        else $error("output overwritten while stalled");

endmodule
`default_nettype wire
